@@ hw/rtl/rna_pkg.sv @@
// Shared types, codes and constants for the radix number to ASCII unit.
// Used by rna_ctrl, rna_datapath and radix_number_to_ascii_unit.
package rna_pkg;

    // Format kinds of an input item
    localparam logic [1:0] KIND_UDEC = 2'd0;
    localparam logic [1:0] KIND_SDEC = 2'd1;
    localparam logic [1:0] KIND_HEX  = 2'd2;
    localparam logic [1:0] KIND_OCT  = 2'd3;

    // Geometry of the digit register: eleven 4-bit slots, most significant on top
    localparam int NUM_SLOTS  = 11;
    localparam int DIG_W      = 4 * NUM_SLOTS;
    localparam int BIN_W      = 32;
    localparam int DEC_DIGITS = 10;
    localparam int HEX_DIGITS = 8;
    localparam int OCT_DIGITS = 11;

    // ASCII codes
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_UPPER = 8'h41;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;
    localparam logic [7:0] ASCII_X     = 8'h78;
    localparam logic [7:0] ASCII_O     = 8'h6F;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] value;
    } rna_in_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } rna_out_t;

    // Which character the datapath puts out this cycle
    typedef enum logic [2:0] {
        OUT_NONE   = 3'd0,
        OUT_MINUS  = 3'd1,
        OUT_ZERO   = 3'd2,
        OUT_LETTER = 3'd3,
        OUT_DIGIT  = 3'd4
    } out_sel_t;

    typedef struct packed {
        logic     load;
        logic     dabble;
        logic     shift;
        out_sel_t out_sel;
    } rna_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       neg;
        logic       lead_zero;
        logic       last_digit;
    } rna_stat_t;

    // Glyph of one digit, upper-case letters above nine
    function automatic logic [7:0] digit_glyph(input logic [3:0] d);
        logic [7:0] g;
        if (d < 4'd10)
            g = ASCII_ZERO + {4'd0, d};
        else
            g = ASCII_UPPER + {4'd0, d} - 8'd10;
        return g;
    endfunction

endpackage

@@ hw/rtl/rna_datapath.sv @@
// Datapath of the radix number to ASCII unit: magnitude, BCD shift-add-3
// register, digit counter and registered character output. Depends on rna_pkg.
module rna_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  rna_pkg::rna_in_t  item,
    input  rna_pkg::rna_cmd_t cmd,
    output rna_pkg::rna_stat_t stat,
    output rna_pkg::rna_out_t result,
    output logic              strobe
);
    import rna_pkg::*;

    logic [DIG_W-1:0] dig_reg, dig_next;
    logic [BIN_W-1:0] bin_reg, bin_next;
    logic [3:0]       cnt_reg, cnt_next;
    logic [1:0]       kind_reg, kind_next;
    logic             neg_reg, neg_next;
    rna_out_t         result_reg, result_next;
    logic             strobe_reg, strobe_next;

    logic [BIN_W-1:0] mag;
    logic [39:0]      bcd_adj;
    logic             load_neg;

    // Magnitude of the incoming value
    always_comb
    begin
        load_neg = (item.kind == KIND_SDEC) && item.value[31];
        mag      = load_neg ? (~item.value + 32'd1) : item.value;
    end

    // Add three to every BCD digit of five or more before the shift
    always_comb
    begin
        for (int i = 0; i < DEC_DIGITS; i++)
        begin
            if (dig_reg[4 + 4*i +: 4] >= 4'd5)
                bcd_adj[4*i +: 4] = dig_reg[4 + 4*i +: 4] + 4'd3;
            else
                bcd_adj[4*i +: 4] = dig_reg[4 + 4*i +: 4];
        end
    end

    // Next state of the digit store
    always_comb
    begin
        dig_next  = dig_reg;
        bin_next  = bin_reg;
        cnt_next  = cnt_reg;
        kind_next = kind_reg;
        neg_next  = neg_reg;
        if (cmd.load)
        begin
            kind_next = item.kind;
            neg_next  = load_neg;
            bin_next  = mag;
            case (item.kind)
                KIND_HEX:
                begin
                    dig_next = {mag, 12'd0};
                    cnt_next = 4'(HEX_DIGITS);
                end
                KIND_OCT:
                begin
                    for (int j = 0; j < NUM_SLOTS - 1; j++)
                        dig_next[4*j +: 4] = {1'b0, mag[3*j +: 3]};
                    dig_next[DIG_W-1 -: 4] = {2'b00, mag[31:30]};
                    cnt_next = 4'(OCT_DIGITS);
                end
                default:
                begin
                    dig_next = '0;
                    cnt_next = 4'(DEC_DIGITS);
                end
            endcase
        end
        else if (cmd.dabble)
        begin
            dig_next = {bcd_adj[38:0], bin_reg[BIN_W-1], 4'd0};
            bin_next = {bin_reg[BIN_W-2:0], 1'b0};
        end
        else if (cmd.shift)
        begin
            dig_next = {dig_reg[DIG_W-5:0], 4'd0};
            cnt_next = cnt_reg - 4'd1;
        end
    end

    // Select the character to put out
    always_comb
    begin
        result_next.last_char = 1'b0;
        strobe_next           = 1'b1;
        case (cmd.out_sel)
            OUT_MINUS:  result_next.char_code = ASCII_MINUS;
            OUT_ZERO:   result_next.char_code = ASCII_ZERO;
            OUT_LETTER: result_next.char_code = (kind_reg == KIND_HEX) ? ASCII_X : ASCII_O;
            OUT_DIGIT:
            begin
                result_next.char_code = digit_glyph(dig_reg[DIG_W-1 -: 4]);
                result_next.last_char = (cnt_reg == 4'd1);
            end
            default:
            begin
                result_next.char_code = result_reg.char_code;
                result_next.last_char = result_reg.last_char;
                strobe_next           = 1'b0;
            end
        endcase
    end

    // Hold the payload registers
    always_ff @(posedge clk)
    begin
        dig_reg    <= dig_next;
        bin_reg    <= bin_next;
        cnt_reg    <= cnt_next;
        kind_reg   <= kind_next;
        neg_reg    <= neg_next;
        result_reg <= result_next;
    end

    // Strobe for each transfer on the result port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strobe_reg <= 1'b0;
        else
            strobe_reg <= strobe_next;
    end

    always_comb
    begin
        stat.kind       = kind_reg;
        stat.neg        = neg_reg;
        stat.lead_zero  = (dig_reg[DIG_W-1 -: 4] == 4'd0) && (cnt_reg > 4'd1);
        stat.last_digit = (cnt_reg == 4'd1);
    end

    assign result = result_reg;
    assign strobe = strobe_reg;

endmodule

@@ hw/rtl/rna_ctrl.sv @@
// Controller of the radix number to ASCII unit: sequences load, BCD
// conversion, prefix, leading-zero drop and digit output. Depends on rna_pkg.
module rna_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  rna_pkg::rna_in_t   item,
    input  rna_pkg::rna_stat_t stat,
    output rna_pkg::rna_cmd_t  cmd,
    output logic               busy
);
    import rna_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_CONV    = 6'b000010,
        ST_PREFIX  = 6'b000100,
        ST_LETTER  = 6'b001000,
        ST_SKIP    = 6'b010000,
        ST_EMIT    = 6'b100000
    } state_t;

    state_t     state_reg, state_next;
    logic [4:0] step_reg, step_next;

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        cmd.load    = 1'b0;
        cmd.dabble  = 1'b0;
        cmd.shift   = 1'b0;
        cmd.out_sel = OUT_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load  = 1'b1;
                    step_next = 5'd0;
                    if (item.kind == KIND_UDEC || item.kind == KIND_SDEC)
                        state_next = ST_CONV;
                    else
                        state_next = ST_PREFIX;
                end
            end
            ST_CONV:
            begin
                cmd.dabble = 1'b1;
                step_next  = step_reg + 5'd1;
                if (step_reg == 5'd31)
                    state_next = ST_PREFIX;
            end
            ST_PREFIX:
            begin
                if (stat.neg)
                begin
                    cmd.out_sel = OUT_MINUS;
                    state_next  = ST_SKIP;
                end
                else if (stat.kind == KIND_HEX || stat.kind == KIND_OCT)
                begin
                    cmd.out_sel = OUT_ZERO;
                    state_next  = ST_LETTER;
                end
                else
                    state_next = ST_SKIP;
            end
            ST_LETTER:
            begin
                cmd.out_sel = OUT_LETTER;
                state_next  = ST_SKIP;
            end
            ST_SKIP:
            begin
                // drop leading zeros, keeping at least one digit
                if (stat.lead_zero)
                    cmd.shift = 1'b1;
                else
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.out_sel = OUT_DIGIT;
                cmd.shift   = 1'b1;
                if (stat.last_digit)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Advance the controller
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= 5'd0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

@@ hw/rtl/radix_number_to_ascii_unit.sv @@
// Radix number to ASCII unit: top level joining rna_ctrl and rna_datapath.
// Depends on rna_pkg.
// Decimal: shift-add-3 conversion in ST_CONV, then the prefix state, then the skip
// state that drops leading zeros, then one character per cycle.
// Hex and octal skip the conversion. Each character is registered and leaves in the
// cycle after it is chosen; the receiver takes it with no stall. Reset returns the unit to idle.
module radix_number_to_ascii_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  rna_pkg::rna_in_t  item,
    output logic              busy,
    output rna_pkg::rna_out_t result,
    output logic              strobe
);
    import rna_pkg::*;

    rna_cmd_t  cmd;
    rna_stat_t stat;

    rna_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .item  (item),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    rna_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .result (result),
        .strobe (strobe)
    );

endmodule

@@ sim/rna_text_checker.sv @@
`timescale 1ns / 100ps
// Character stream checker for the radix number to ASCII unit: predicts the text of
// every accepted number and compares each strobed character against it in order.
// Depends on rna_pkg; instantiated beside u_dut by radix_number_to_ascii_unit_tb.
module rna_text_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  rna_pkg::rna_in_t   item,
    input  rna_pkg::rna_out_t  result,
    input  logic               strobe,
    output int                 fails,
    output int                 outstanding
);
    import rna_pkg::*;

    // Digit glyphs, character d sits at bits [8*(15-d) +: 8]
    localparam logic [127:0] GLYPHS = "0123456789ABCDEF";

    rna_out_t text_q [$];
    rna_out_t want;
    int       mismatch_cnt = 0;

    // Queue the characters that one number is expected to print
    function automatic void format_number(input rna_in_t num);
        logic [7:0]  txt [13];
        int          digs [12];
        logic [31:0] mag;
        logic [31:0] base;
        logic [31:0] rem;
        int          len;
        int          ndig;
        rna_out_t    ch;
        len  = 0;
        ndig = 0;
        mag  = num.value;
        case (num.kind)
            KIND_HEX: base = 32'd16;
            KIND_OCT: base = 32'd8;
            default:  base = 32'd10;
        endcase
        // sign or radix prefix
        if (num.kind == KIND_SDEC && mag[31])
        begin
            txt[0] = ASCII_MINUS;
            len    = 1;
            mag    = -mag;
        end
        else if (num.kind == KIND_HEX || num.kind == KIND_OCT)
        begin
            txt[0] = ASCII_ZERO;
            txt[1] = (num.kind == KIND_HEX) ? ASCII_X : ASCII_O;
            len    = 2;
        end
        // collect digits least significant first; zero still yields one digit
        do
        begin
            rem        = mag % base;
            digs[ndig] = int'(rem);
            mag        = mag / base;
            ndig++;
        end
        while (mag != 32'd0);
        for (int i = ndig - 1; i >= 0; i--)
        begin
            txt[len] = GLYPHS[8 * (15 - digs[i]) +: 8];
            len++;
        end
        // flag the final character
        for (int i = 0; i < len; i++)
        begin
            ch.char_code = txt[i];
            ch.last_char = (i == len - 1);
            text_q.push_back(ch);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // compare each strobed character with the oldest prediction
            if (strobe)
            begin
                if (text_q.size() == 0)
                begin
                    $display("%0t: unexpected character: expected none, actual %h last %b",
                             $time, result.char_code, result.last_char);
                    mismatch_cnt++;
                end
                else
                begin
                    want = text_q.pop_front();
                    if (result.char_code !== want.char_code)
                    begin
                        $display("%0t: char_code mismatch: expected %h, actual %h",
                                 $time, want.char_code, result.char_code);
                        mismatch_cnt++;
                    end
                    if (result.last_char !== want.last_char)
                    begin
                        $display("%0t: last_char mismatch: expected %b, actual %b",
                                 $time, want.last_char, result.last_char);
                        mismatch_cnt++;
                    end
                end
            end
            // predict the text of a number on its transfer
            if (start && !busy)
                format_number(item);
        end
        fails       <= mismatch_cnt;
        outstanding <= text_q.size();
    end

endmodule

@@ sim/radix_number_to_ascii_unit_tb.sv @@
`timescale 1ns / 100ps
// Top of the radix number to ASCII unit testbench: drives numbers of every kind
// into u_dut and gives the verdict. Depends on rna_pkg and rna_text_checker.
module radix_number_to_ascii_unit_tb;
    import rna_pkg::*;

    localparam int QUIET_LIMIT      = 2000;
    localparam int SETTLE_CYCLES    = 60;
    localparam int NUMS_PER_PHASE   = 102;

    logic     clk   = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    rna_in_t  item  = '0;
    logic     busy;
    rna_out_t result;
    logic     strobe;
    int       fails;
    int       outstanding;
    int       quiet_cycles = 0;
    int       idle_pct     = 0;

    logic [1:0] kinds [4] = '{KIND_UDEC, KIND_SDEC, KIND_HEX, KIND_OCT};

    radix_number_to_ascii_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .result (result),
        .strobe (strobe)
    );

    rna_text_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .item        (item),
        .result      (result),
        .strobe      (strobe),
        .fails       (fails),
        .outstanding (outstanding)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // End the run when nothing has been transferred for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("radix_number_to_ascii_unit test failed");
            $finish;
        end
    end

    // Hold a number on the inputs until the unit takes it, after a random gap
    task automatic send_number(input rna_in_t num);
        while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item  <= num;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Drop start and wait for every predicted character to arrive
    task automatic wait_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // Values weighted towards digit-count and sign boundaries
    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        logic [31:0] pow10;
        int          sel;
        sel   = $urandom_range(0, 9);
        pow10 = 32'd1;
        repeat ($urandom_range(0, 9))
            pow10 = pow10 * 32'd10;
        case (sel)
            0, 1, 2, 3: v = $urandom;
            4:          v = $urandom_range(0, 20);
            5:          v = (32'd1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
            6:          v = pow10 + $urandom_range(0, 2) - 32'd1;
            7:          v = -(pow10 + $urandom_range(0, 2) - 32'd1);
            8:          v = $urandom & ((32'd1 << $urandom_range(1, 31)) - 32'd1);
            default:    v = $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 2) - 32'd1
                                                 : 32'hFFFF_FFFF - $urandom_range(0, 2);
        endcase
        return v;
    endfunction

    initial
    begin
        rna_in_t directed [$];
        int      phase_idle [4];
        rna_in_t num;

        phase_idle = '{0, 63, 0, 19};

        // Hold reset, then release it
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extremes of every kind: zero, all ones, most negative, most positive
        foreach (kinds[k])
        begin
            directed.push_back({kinds[k], 32'h0000_0000});
            directed.push_back({kinds[k], 32'hFFFF_FFFF});
            directed.push_back({kinds[k], 32'h8000_0000});
            directed.push_back({kinds[k], 32'h7FFF_FFFF});
        end
        // Digit-count steps, small negatives and every glyph
        directed.push_back({KIND_UDEC, 32'd9});
        directed.push_back({KIND_UDEC, 32'd10});
        directed.push_back({KIND_UDEC, 32'd1000000000});
        directed.push_back({KIND_SDEC, 32'h8000_0001});
        directed.push_back({KIND_SDEC, 32'hFFFF_FFF6});
        directed.push_back({KIND_HEX,  32'h0123_ABCD});
        directed.push_back({KIND_HEX,  32'hFEDC_BA98});
        directed.push_back({KIND_OCT,  32'h1234_5678});

        foreach (directed[i])
            send_number(directed[i]);
        wait_drained();

        // Random numbers under several sender idling rates, fully drained between
        foreach (phase_idle[p])
        begin
            idle_pct = phase_idle[p];
            repeat (NUMS_PER_PHASE)
            begin
                num.kind  = kinds[$urandom_range(0, 3)];
                num.value = pick_value();
                send_number(num);
            end
            wait_drained();
        end

        // Let any stray character show before the verdict
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (fails == 0 && outstanding == 0)
            $display("radix_number_to_ascii_unit test passed");
        else
            $display("radix_number_to_ascii_unit test failed");
        $finish;
    end

endmodule
